/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL; both sample on clk_i.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked outside reset only
`define AST_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked at every edge, reset included
`define AST_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define AST_CHK(lbl, prop, msg)
`define AST_NR(lbl, prop, msg)
`endif

`endif

/* hw/rtl/wlmf_pkg.sv */
package wlmf_pkg;

  localparam int MaxPeaks = 16;
  localparam int IdxW     = $clog2(MaxPeaks);
  localparam int PosW     = 10;
  localparam int AmpW     = 12;
  localparam int SmpW     = 13;
  localparam int TotW     = 5;

  localparam logic [AmpW-1:0] ValleyReset = '1;

  typedef enum logic [1:0] {
    SignZero = 2'd0,
    SignPos  = 2'd1,
    SignNeg  = 2'd2
  } sign_e;

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StEmit = 2'b10
  } state_e;

  typedef struct packed {
    logic accept;    // take one sample into the tracker
    logic emit_adv;  // result transfer done, step to next entry
    logic clear;     // end of run, back to reset values
  } cmd_t;

  typedef struct packed {
    logic last_entry;
  } status_t;

endpackage

/* hw/rtl/waveform_local_maxima_finder_top.sv */
// Channel  Direction  Handshake               Payload
// in       input      in_valid_i / in_stall_o    sample_value_i, last_sample_i
// out      output     out_valid_o / out_stall_i  peak_position_o, peak_amplitude_o,
//                                                peak_total_o, overflow_o, last_peak_o
//
// One sample per cycle while in_stall_o is low; the tracker updates in the cycle of the transfer.
// After the last sample the controller walks the peak store one entry per
// cycle while out_stall_i is low: peak_total results, each held while out_stall_i is high.
// Input is stalled for the whole emission; the run state clears with the
// final result transfer.
// rst_ni is asynchronous, active low, and clears all run state and store flags.
module waveform_local_maxima_finder_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [wlmf_pkg::SmpW-1:0] sample_value_i,
  input  logic                             last_sample_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic        [wlmf_pkg::PosW-1:0] peak_position_o,
  output logic        [wlmf_pkg::AmpW-1:0] peak_amplitude_o,
  output logic        [wlmf_pkg::TotW-1:0] peak_total_o,
  output logic                             overflow_o,
  output logic                             last_peak_o
);
  import wlmf_pkg::*;

  cmd_t    cmd;
  status_t status;

  wlmf_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .last_sample_i (last_sample_i),
    .out_stall_i   (out_stall_i),
    .status_i      (status),
    .in_stall_o    (in_stall_o),
    .out_valid_o   (out_valid_o),
    .cmd_o         (cmd)
  );

  wlmf_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sample_value_i   (sample_value_i),
    .status_o         (status),
    .peak_position_o  (peak_position_o),
    .peak_amplitude_o (peak_amplitude_o),
    .peak_total_o     (peak_total_o),
    .overflow_o       (overflow_o),
    .last_peak_o      (last_peak_o)
  );

endmodule

/* hw/rtl/wlmf_ctrl.sv */
`include "assert_macros.svh"

module wlmf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              last_sample_i,
  input  logic              out_stall_i,
  input  wlmf_pkg::status_t status_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  output wlmf_pkg::cmd_t    cmd_o
);
  import wlmf_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (last_sample_i) begin
            state_d = StEmit;
          end
        end
      end
      StEmit: begin
        if (!out_stall_i) begin
          cmd_o.emit_adv = 1'b1;
          if (status_i.last_entry) begin
            cmd_o.clear = 1'b1;
            state_d     = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = (state_q == StEmit);

  `AST_CHK(a_last_starts_emit, in_valid_i && !in_stall_o && last_sample_i |=> out_valid_o, "last sample did not start emission")
  `AST_CHK(a_final_ends_emit, out_valid_o && !out_stall_i && status_i.last_entry |=> !out_valid_o && !in_stall_o, "emission did not end after final transfer")
  `AST_NR(a_no_accept_in_emit, out_valid_o |-> in_stall_o, "input open during emission")

endmodule

/* hw/rtl/wlmf_dp.sv */
`include "assert_macros.svh"

module wlmf_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  wlmf_pkg::cmd_t                   cmd_i,
  input  logic signed [wlmf_pkg::SmpW-1:0] sample_value_i,
  output wlmf_pkg::status_t                status_o,
  output logic        [wlmf_pkg::PosW-1:0] peak_position_o,
  output logic        [wlmf_pkg::AmpW-1:0] peak_amplitude_o,
  output logic        [wlmf_pkg::TotW-1:0] peak_total_o,
  output logic                             overflow_o,
  output logic                             last_peak_o
);
  import wlmf_pkg::*;

  logic [AmpW-1:0] ref_q, ref_d;
  logic [AmpW-1:0] valley_q, valley_d;
  logic [AmpW-1:0] cur_q, cur_d;
  sign_e           sign_q, sign_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [PosW-1:0] pos_q;
  logic            ovf_q, ovf_d;
  logic [IdxW-1:0] emit_q;

  logic [PosW-1:0] pos_store_q [MaxPeaks];
  logic [AmpW-1:0] amp_store_q [MaxPeaks];
  logic [MaxPeaks-1:0] valid_q;

  logic            wr_en;
  logic [IdxW-1:0] wr_idx;
  logic [AmpW-1:0] smp;
  logic            smp_pos, rise, fall;

  assign smp     = sample_value_i[AmpW-1:0];
  assign smp_pos = !sample_value_i[SmpW-1] && (sample_value_i != '0);
  assign rise    = smp > ref_q;
  assign fall    = smp < ref_q;

  always_comb begin
    ref_d    = ref_q;
    valley_d = valley_q;
    cur_d    = cur_q;
    sign_d   = sign_q;
    idx_d    = idx_q;
    ovf_d    = ovf_q;
    wr_en    = 1'b0;
    wr_idx   = idx_q;
    if (cmd_i.accept && smp_pos) begin
      if (rise) begin
        if (sign_q == SignPos) begin
          if (smp > cur_q) begin
            cur_d = smp;
            wr_en = !ovf_q;
          end
          ref_d = (smp > cur_q) ? smp : cur_q;
        end else begin
          // rise after a fall or flat step: new peak
          ref_d = valley_q;
          if (!ovf_q && (idx_q != IdxW'(MaxPeaks - 1))) begin
            idx_d = idx_q + IdxW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          cur_d  = smp;
          wr_en  = !ovf_d;
          wr_idx = idx_d;
        end
        sign_d = SignPos;
      end else begin
        if (fall && (sign_q == SignNeg)) begin
          valley_d = (smp < valley_q) ? smp : valley_q;
          ref_d    = valley_d;
        end else begin
          ref_d    = cur_q;
          valley_d = smp;
        end
        sign_d = fall ? SignNeg : SignZero;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q    <= '0;
      valley_q <= ValleyReset;
      cur_q    <= '0;
      sign_q   <= SignPos;
      idx_q    <= '0;
      pos_q    <= '0;
      ovf_q    <= 1'b0;
      emit_q   <= '0;
      valid_q  <= '0;
    end else if (cmd_i.clear) begin
      ref_q    <= '0;
      valley_q <= ValleyReset;
      cur_q    <= '0;
      sign_q   <= SignPos;
      idx_q    <= '0;
      pos_q    <= '0;
      ovf_q    <= 1'b0;
      emit_q   <= '0;
      valid_q  <= '0;
    end else begin
      ref_q    <= ref_d;
      valley_q <= valley_d;
      cur_q    <= cur_d;
      sign_q   <= sign_d;
      idx_q    <= idx_d;
      ovf_q    <= ovf_d;
      if (cmd_i.accept) begin
        pos_q <= pos_q + PosW'(1);
      end
      if (cmd_i.emit_adv) begin
        emit_q <= emit_q + IdxW'(1);
      end
      if (wr_en) begin
        valid_q[wr_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pos_store_q[wr_idx] <= pos_q;
      amp_store_q[wr_idx] <= cur_d;
    end
  end

  assign status_o.last_entry = (emit_q == idx_q);

  assign peak_position_o  = valid_q[emit_q] ? pos_store_q[emit_q] : '0;
  assign peak_amplitude_o = valid_q[emit_q] ? amp_store_q[emit_q] : '0;
  assign peak_total_o     = TotW'(idx_q) + TotW'(1);
  assign overflow_o       = ovf_q;
  assign last_peak_o      = status_o.last_entry;

  `AST_CHK(a_ovf_sticky, ovf_q && !cmd_i.clear |=> ovf_q, "overflow dropped within a run")
  `AST_CHK(a_emit_hold, !cmd_i.emit_adv && !cmd_i.clear |=> $stable(emit_q), "emission index moved without transfer")
  `AST_CHK(a_idx_hold_emit, cmd_i.emit_adv && !cmd_i.clear |=> $stable(idx_q), "peak count changed during emission")

endmodule

/* tb/sv/waveform_local_maxima_finder_top_test.sv */
`timescale 1ns / 100ps

module waveform_local_maxima_finder_top_test;
  import wlmf_pkg::*;

  typedef struct {
    logic [PosW-1:0] pos;
    logic [AmpW-1:0] amp;
    logic [TotW-1:0] total;
    logic            ovf;
    logic            last;
  } peak_rec_t;

  // Tracks the waveform the way the block does and queues the peak list it should emit
  class peak_list_tracker;
    peak_rec_t       expected_peaks[$];
    int              mismatches;
    int              ref_level;
    sign_e           prev_sign;
    int              valley;
    int              peak_idx;
    int              pos_cnt;
    int              cur_peak;
    logic            ovf;
    logic [PosW-1:0] pos_store[MaxPeaks];
    logic [AmpW-1:0] amp_store[MaxPeaks];

    function new();
      mismatches = 0;
      clear_run();
    endfunction

    function void clear_run();
      ref_level = 0;
      prev_sign = SignPos;
      valley    = int'(ValleyReset);
      peak_idx  = 0;
      pos_cnt   = 0;
      cur_peak  = 0;
      ovf       = 1'b0;
      foreach (pos_store[k]) begin
        pos_store[k] = '0;
        amp_store[k] = '0;
      end
    endfunction

    function void store_peak(int pos);
      if (!ovf && peak_idx < MaxPeaks) begin
        pos_store[peak_idx] = PosW'(pos);
        amp_store[peak_idx] = AmpW'(cur_peak);
      end
    endfunction

    function void track(int content, int pos);
      int slope;
      if (content <= 0) return;
      slope = content - ref_level;
      if (slope > 0) begin
        if (prev_sign == SignPos) begin
          if (content > cur_peak) begin
            cur_peak = content;
            store_peak(pos);
          end
          ref_level = cur_peak;
        end else begin
          // rise after a fall or flat step opens a new peak
          ref_level = valley;
          if (!ovf && peak_idx + 1 < MaxPeaks) peak_idx++;
          else ovf = 1'b1;
          cur_peak = content;
          store_peak(pos);
        end
        prev_sign = SignPos;
      end else begin
        if (slope < 0 && prev_sign == SignNeg) begin
          if (content < valley) valley = content;
          ref_level = valley;
        end else begin
          ref_level = cur_peak;
          valley    = content;
        end
        if (slope < 0) prev_sign = SignNeg;
        else prev_sign = SignZero;
      end
    endfunction

    function void note_sample(logic signed [SmpW-1:0] value, logic last);
      peak_rec_t rec;
      int        count;
      track(int'(value), pos_cnt);
      pos_cnt = (pos_cnt + 1) % (1 << PosW);
      if (!last) return;
      count = peak_idx + 1;
      if (count > MaxPeaks) count = MaxPeaks;
      for (int k = 0; k < count; k++) begin
        rec.pos   = pos_store[k];
        rec.amp   = amp_store[k];
        rec.total = TotW'(count);
        rec.ovf   = ovf;
        rec.last  = (k + 1 == count);
        expected_peaks.insert(expected_peaks.size(), rec);
      end
      clear_run();
    endfunction

    function void check_peak(logic [PosW-1:0] pos, logic [AmpW-1:0] amp,
                             logic [TotW-1:0] total, logic o, logic last);
      peak_rec_t exp_rec;
      if (expected_peaks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected peak: pos %0d amp %0d total %0d ovf %0b last %0b",
                   pos, amp, total, o, last);
        return;
      end
      exp_rec = expected_peaks.pop_front();
      if (pos !== exp_rec.pos || amp !== exp_rec.amp || total !== exp_rec.total ||
          o !== exp_rec.ovf || last !== exp_rec.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("peak mismatch: exp pos %0d amp %0d total %0d ovf %0b last %0b,",
                   exp_rec.pos, exp_rec.amp, exp_rec.total, exp_rec.ovf, exp_rec.last,
                   " got pos %0d amp %0d total %0d ovf %0b last %0b",
                   pos, amp, total, o, last);
      end
    endfunction

    function int pending();
      return expected_peaks.size();
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic signed [SmpW-1:0] sample_value_i = '0;
  logic                   last_sample_i = 1'b0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic        [PosW-1:0] peak_position_o;
  logic        [AmpW-1:0] peak_amplitude_o;
  logic        [TotW-1:0] peak_total_o;
  logic                   overflow_o;
  logic                   last_peak_o;

  peak_list_tracker tracker;
  int idle_pct = 0;
  int stall_pct = 0;
  int samples_sent = 0;
  int walk_level = 1;

  waveform_local_maxima_finder_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .sample_value_i   (sample_value_i),
    .last_sample_i    (last_sample_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .peak_position_o  (peak_position_o),
    .peak_amplitude_o (peak_amplitude_o),
    .peak_total_o     (peak_total_o),
    .overflow_o       (overflow_o),
    .last_peak_o      (last_peak_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99, 0) < stall_pct);
  end

  // Transfers are observed on the pre-edge values
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        tracker.note_sample(sample_value_i, last_sample_i);
      if (out_valid_o && !out_stall_i)
        tracker.check_peak(peak_position_o, peak_amplitude_o, peak_total_o,
                           overflow_o, last_peak_o);
    end
  end

  task automatic send_sample(input logic signed [SmpW-1:0] s, input logic last);
    if ($urandom_range(99, 0) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99, 0) < idle_pct);
    end
    in_valid_i     <= 1'b1;
    sample_value_i <= s;
    last_sample_i  <= last;
    do @(posedge clk_i); while (in_stall_o);
    samples_sent++;
  endtask

  task automatic next_sample(output logic signed [SmpW-1:0] s);
    int r;
    int d;
    r = $urandom_range(99, 0);
    if (r < 70) begin
      d = $urandom_range(99, 0);
      if (d < 12) ;  // flat step
      else if (d < 56) walk_level += $urandom_range(600, 1);
      else walk_level -= $urandom_range(600, 1);
      if (walk_level < 1) walk_level = 1;
      if (walk_level > 4095) walk_level = 4095;
      s = SmpW'(walk_level);
    end else if (r < 80) begin
      s = SmpW'(-int'($urandom_range(4096, 0)));
    end else if (r < 90) begin
      s = SmpW'($urandom_range(8191, 0));
    end else begin
      case ($urandom_range(4, 0))
        0: s = 13'sd4095;
        1: s = 13'sd1;
        2: s = -13'sd1;
        3: s = -13'sd4096;
        default: s = '0;
      endcase
    end
  endtask

  task automatic send_shaped_run();
    int len;
    logic signed [SmpW-1:0] s;
    len = $urandom_range(20, 2);
    walk_level = $urandom_range(4095, 1);
    for (int k = 0; k < len; k++) begin
      next_sample(s);
      send_sample(s, k == len - 1);
    end
  endtask

  task automatic send_noise_run();
    int len;
    len = $urandom_range(8, 1);
    for (int k = 0; k < len; k++)
      send_sample(SmpW'($urandom_range(8191, 0)), k == len - 1);
  endtask

  // alternating high/low samples in a long run open many new peaks, to drive the store toward overflow
  task automatic send_comb_run();
    int len;
    len = $urandom_range(38, 34);
    for (int k = 0; k < len; k++) begin
      if (k % 2 == 0) send_sample(SmpW'($urandom_range(4095, 2000)), k == len - 1);
      else send_sample(SmpW'($urandom_range(1500, 1)), k == len - 1);
    end
  endtask

  initial begin
    int start;
    int idle_tab[4];
    int stall_tab[4];
    idle_tab  = '{0, 75, 0, 27};
    stall_tab = '{0, 0, 75, 27};
    tracker = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // no positive sample at all, then a single full-scale one
    send_sample(-13'sd4096, 1'b1);
    send_sample(13'sd4095, 1'b1);
    // falls, flat steps, new valleys, skipped samples and new peaks
    send_sample(13'sd100, 1'b0);
    send_sample(13'sd50, 1'b0);
    send_sample(13'sd50, 1'b0);
    send_sample(13'sd0, 1'b0);
    send_sample(13'sd200, 1'b0);
    send_sample(13'sd200, 1'b0);
    send_sample(13'sd300, 1'b0);
    send_sample(-13'sd1, 1'b0);
    send_sample(13'sd4095, 1'b0);
    send_sample(13'sd20, 1'b0);
    send_sample(13'sd20, 1'b0);
    send_sample(13'sd1, 1'b0);
    send_sample(13'sd4095, 1'b1);
    send_sample(13'sd1, 1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_tab[ph];
      stall_pct = stall_tab[ph];
      if (ph == 0) send_comb_run();
      start = samples_sent;
      while (samples_sent - start < 10) begin
        case ($urandom_range(9, 0))
          8: send_noise_run();
          default: send_shaped_run();
        endcase
      end
    end
    in_valid_i <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("status: fail");
    $finish;
  end

endmodule
